// ===== hdl/mtep_pkg.sv =====
// Shared types and codes for the MIDI track event parser.
// No dependencies; imported by every module of the block.
package mtep_pkg;

   // Width of variable-length numbers, deltas and skip counts
   localparam int VLQ_W = 28;

   // Result kinds
   localparam logic [2:0] KIND_CHANNEL   = 3'd0;
   localparam logic [2:0] KIND_TEMPO     = 3'd1;
   localparam logic [2:0] KIND_TIME_SIG  = 3'd2;
   localparam logic [2:0] KIND_END_TRACK = 3'd3;
   localparam logic [2:0] KIND_BAD_TAG   = 3'd4;
   localparam logic [2:0] KIND_NO_STATUS = 3'd5;

   // Status bytes with special handling
   localparam logic [7:0] STATUS_META       = 8'hFF;
   localparam logic [7:0] STATUS_SYSEX      = 8'hF0;
   localparam logic [7:0] STATUS_SYSEX_ESC  = 8'hF7;
   localparam logic [7:0] STATUS_SYSTEM_MIN = 8'hF0;

   // Meta event types that produce results
   localparam logic [7:0] META_END_TRACK = 8'h2F;
   localparam logic [7:0] META_TEMPO     = 8'h51;
   localparam logic [7:0] META_TIME_SIG  = 8'h58;

   // Status high nibbles that carry a single data byte
   localparam logic [3:0] NIBBLE_PROGRAM  = 4'hC;
   localparam logic [3:0] NIBBLE_PRESSURE = 4'hD;

   // Parser phases
   typedef enum logic [3:0] {
      PH_TAG,
      PH_LEN,
      PH_DELTA,
      PH_EVENT,
      PH_DATA1,
      PH_DATA2,
      PH_MTYPE,
      PH_MLEN,
      PH_MBODY,
      PH_SYSLEN,
      PH_SKIP,
      PH_DONE,
      PH_HALT
   } phase_type;

   // One result beat
   typedef struct packed {
      logic [2:0]       event_kind;
      logic [VLQ_W-1:0] delta_ticks;
      logic [7:0]       status_value;
      logic [6:0]       first_data;
      logic [6:0]       second_data;
      logic [23:0]      tempo_value;
      logic [7:0]       meter_numerator;
      logic [7:0]       meter_denominator_exp;
   } rsp_type;

endpackage

// ===== hdl/mtep_parse.sv =====
// Byte-at-a-time track parser: parse state registers and the next-state and
// result logic for one byte. Depends on mtep_pkg.
module mtep_parse import mtep_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        byte_accept,
   input  logic [7:0]  data_byte,
   input  logic        track_start,
   output logic        res_valid,
   output rsp_type     res_beat
);

   // Parse state
   phase_type        phase_ff, phase_in;
   logic [2:0]       pos_ff, pos_in;
   logic [VLQ_W-1:0] acc_ff, acc_in;
   logic [VLQ_W-1:0] delta_ff, delta_in;
   logic [7:0]       rstat_ff, rstat_in;
   logic [7:0]       meta_ff, meta_in;
   logic [VLQ_W-1:0] skip_ff, skip_in;
   logic [23:0]      held_ff, held_in;

   // Expected tag byte, "MTrk"
   function automatic logic [7:0] tag_byte(input logic [1:0] idx);
      logic [7:0] t;
      begin
         case (idx)
            2'd0:    t = 8'h4D;
            2'd1:    t = 8'h54;
            2'd2:    t = 8'h72;
            default: t = 8'h6B;
         endcase
         return t;
      end
   endfunction

   // Result for a completed meta event
   function automatic rsp_type meta_result(input logic [7:0] mt, input logic [2:0] np,
                                           input logic [23:0] hb,
                                           input logic [VLQ_W-1:0] dl);
      rsp_type r;
      begin
         r = '0;
         r.delta_ticks = dl;
         unique case (mt)
            META_END_TRACK: r.event_kind = KIND_END_TRACK;
            META_TEMPO: begin
               r.event_kind = KIND_TEMPO;
               case (np)
                  3'd0:    r.tempo_value = '0;
                  3'd1:    r.tempo_value = {16'd0, hb[23:16]};
                  3'd2:    r.tempo_value = {8'd0, hb[23:8]};
                  default: r.tempo_value = hb;
               endcase
            end
            META_TIME_SIG: begin
               r.event_kind            = KIND_TIME_SIG;
               r.meter_numerator       = hb[23:16];
               r.meter_denominator_exp = hb[15:8];
            end
            default: r.event_kind = KIND_CHANNEL;
         endcase
         return r;
      end
   endfunction

   // Next state and result for the byte at the input
   always_comb begin
      phase_type        c_phase;
      logic [2:0]       c_pos;
      logic [VLQ_W-1:0] c_acc;
      logic [VLQ_W-1:0] c_delta;
      logic [7:0]       c_rstat;
      logic [7:0]       c_meta;
      logic [VLQ_W-1:0] c_skip;
      logic [23:0]      c_held;
      logic [VLQ_W-1:0] acc_take;
      logic [VLQ_W-1:0] skip_dec;
      logic             meta_hit;
      logic             do_data1;
      logic [3:0]       nib;

      // Start of chunk clears everything before this byte is parsed
      if (track_start) begin
         c_phase = PH_TAG;
         c_pos   = '0;
         c_acc   = '0;
         c_delta = '0;
         c_rstat = '0;
         c_meta  = '0;
         c_skip  = '0;
         c_held  = '0;
      end else begin
         c_phase = phase_ff;
         c_pos   = pos_ff;
         c_acc   = acc_ff;
         c_delta = delta_ff;
         c_rstat = rstat_ff;
         c_meta  = meta_ff;
         c_skip  = skip_ff;
         c_held  = held_ff;
      end

      acc_take = {c_acc[VLQ_W-8:0], data_byte[6:0]};
      skip_dec = c_skip - VLQ_W'(1);
      meta_hit = (c_meta == META_END_TRACK) || (c_meta == META_TEMPO) ||
                 (c_meta == META_TIME_SIG);
      do_data1 = 1'b0;
      nib      = c_rstat[7:4];

      phase_in  = c_phase;
      pos_in    = c_pos;
      acc_in    = c_acc;
      delta_in  = c_delta;
      rstat_in  = c_rstat;
      meta_in   = c_meta;
      skip_in   = c_skip;
      held_in   = c_held;
      res_valid = 1'b0;
      res_beat  = '0;

      unique case (c_phase)
         // Check the chunk tag
         PH_TAG: begin
            if (data_byte != tag_byte(c_pos[1:0])) begin
               res_valid           = 1'b1;
               res_beat.event_kind = KIND_BAD_TAG;
               phase_in            = PH_HALT;
            end else if (c_pos == 3'd3) begin
               pos_in   = '0;
               phase_in = PH_LEN;
            end else begin
               pos_in = c_pos + 3'd1;
            end
         end
         // Skip the chunk length
         PH_LEN: begin
            if (c_pos == 3'd3) begin
               pos_in   = '0;
               acc_in   = '0;
               phase_in = PH_DELTA;
            end else begin
               pos_in = c_pos + 3'd1;
            end
         end
         // Gather the delta time
         PH_DELTA: begin
            if (!data_byte[7]) begin
               delta_in = acc_take;
               acc_in   = '0;
               phase_in = PH_EVENT;
            end else begin
               acc_in = acc_take;
            end
         end
         // Decode the status position
         PH_EVENT: begin
            if (data_byte == STATUS_META) begin
               phase_in = PH_MTYPE;
            end else if (data_byte == STATUS_SYSEX || data_byte == STATUS_SYSEX_ESC) begin
               acc_in   = '0;
               phase_in = PH_SYSLEN;
            end else if (data_byte >= STATUS_SYSTEM_MIN) begin
               rstat_in              = '0;
               res_valid             = 1'b1;
               res_beat.event_kind   = KIND_CHANNEL;
               res_beat.delta_ticks  = c_delta;
               res_beat.status_value = data_byte;
               phase_in              = PH_DELTA;
               acc_in                = '0;
            end else if (data_byte[7]) begin
               rstat_in = data_byte;
               phase_in = PH_DATA1;
            end else if (c_rstat == 8'd0) begin
               res_valid            = 1'b1;
               res_beat.event_kind  = KIND_NO_STATUS;
               res_beat.delta_ticks = c_delta;
               phase_in             = PH_DELTA;
               acc_in               = '0;
            end else begin
               do_data1 = 1'b1;
            end
         end
         PH_DATA1: do_data1 = 1'b1;
         // Second data byte completes the message
         PH_DATA2: begin
            res_valid             = 1'b1;
            res_beat.event_kind   = KIND_CHANNEL;
            res_beat.delta_ticks  = c_delta;
            res_beat.status_value = c_rstat;
            res_beat.first_data   = c_held[6:0];
            res_beat.second_data  = data_byte[6:0];
            phase_in              = PH_DELTA;
            acc_in                = '0;
         end
         PH_MTYPE: begin
            meta_in  = data_byte;
            acc_in   = '0;
            phase_in = PH_MLEN;
         end
         // Meta length; an empty body finishes at once
         PH_MLEN: begin
            if (!data_byte[7]) begin
               skip_in = acc_take;
               acc_in  = '0;
               held_in = '0;
               pos_in  = '0;
               if (acc_take == '0) begin
                  phase_in  = (c_meta == META_END_TRACK) ? PH_DONE : PH_DELTA;
                  res_valid = meta_hit;
                  res_beat  = meta_result(c_meta, 3'd0, 24'd0, c_delta);
               end else begin
                  phase_in = PH_MBODY;
               end
            end else begin
               acc_in = acc_take;
            end
         end
         // Capture up to three body bytes and count the body down
         PH_MBODY: begin
            logic [23:0] nh;
            logic [2:0]  np;
            nh = c_held;
            np = c_pos;
            case (c_pos)
               3'd0:    begin nh[23:16] = data_byte; np = 3'd1; end
               3'd1:    begin nh[15:8]  = data_byte; np = 3'd2; end
               3'd2:    begin nh[7:0]   = data_byte; np = 3'd3; end
               default: begin nh = c_held; np = c_pos; end
            endcase
            held_in = nh;
            pos_in  = np;
            skip_in = skip_dec;
            if (skip_dec == '0) begin
               acc_in    = '0;
               phase_in  = (c_meta == META_END_TRACK) ? PH_DONE : PH_DELTA;
               res_valid = meta_hit;
               res_beat  = meta_result(c_meta, np, nh, c_delta);
            end
         end
         // Sysex length
         PH_SYSLEN: begin
            if (!data_byte[7]) begin
               skip_in  = acc_take;
               acc_in   = '0;
               phase_in = (acc_take == '0) ? PH_DELTA : PH_SKIP;
            end else begin
               acc_in = acc_take;
            end
         end
         // Drop the sysex body
         PH_SKIP: begin
            skip_in = skip_dec;
            if (skip_dec == '0) begin
               acc_in   = '0;
               phase_in = PH_DELTA;
            end
         end
         PH_DONE: phase_in = c_phase;
         PH_HALT: phase_in = c_phase;
         default: phase_in = c_phase;
      endcase

      // First data byte, shared by the data phase and running status
      if (do_data1) begin
         if (nib == NIBBLE_PROGRAM || nib == NIBBLE_PRESSURE) begin
            res_valid             = 1'b1;
            res_beat.event_kind   = KIND_CHANNEL;
            res_beat.delta_ticks  = c_delta;
            res_beat.status_value = c_rstat;
            res_beat.first_data   = data_byte[6:0];
            phase_in              = PH_DELTA;
            acc_in                = '0;
         end else begin
            held_in  = {17'd0, data_byte[6:0]};
            phase_in = PH_DATA2;
         end
      end
   end

   // Advance the parse state on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TAG;
         pos_ff   <= '0;
         acc_ff   <= '0;
         delta_ff <= '0;
         rstat_ff <= '0;
         meta_ff  <= '0;
         skip_ff  <= '0;
         held_ff  <= '0;
      end else if (byte_accept) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         acc_ff   <= acc_in;
         delta_ff <= delta_in;
         rstat_ff <= rstat_in;
         meta_ff  <= meta_in;
         skip_ff  <= skip_in;
         held_ff  <= held_in;
      end
   end

   // Byte position never passes the last tag or captured body byte
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= 3'd3)
      else $error("byte position out of range");

   // A bad tag parks the parser until the next chunk start
   a_bad_tag_halts: assert property (@(posedge clock) disable iff (reset)
      byte_accept && res_valid && res_beat.event_kind == KIND_BAD_TAG
      |=> phase_ff == PH_HALT)
      else $error("bad tag did not halt the parser");

endmodule

// ===== hdl/mtep_rsp_buf.sv =====
// Two-entry result buffer: an output register plus a skid register.
// Depends on mtep_pkg for the result beat type.
module mtep_rsp_buf import mtep_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_beat,
   output logic    space,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_beat
);

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    pop;

   assign pop       = main_valid_ff && out_ready;
   assign space     = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_beat  = main_ff;

   // Load pushes into the free slot and move beats from the skid slot to the output slot in order
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (main_valid_ff && !pop) begin
         if (push) begin
            skid_in       = push_beat;
            skid_valid_in = 1'b1;
         end
      end else if (push) begin
         main_in       = push_beat;
         main_valid_in = 1'b1;
      end else begin
         main_valid_in = 1'b0;
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid slot full while output slot empty");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !skid_valid_ff)
      else $error("beat pushed into a full buffer");

   a_skid_moves_up: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && pop |=> main_valid_ff && main_ff == $past(skid_ff))
      else $error("skid beat lost on output pop");

endmodule

// ===== hdl/midi_track_event_parser_core.sv =====
// Top level of the MIDI track event parser: byte parser and result buffer.
// Depends on mtep_pkg, mtep_parse and mtep_rsp_buf.
//
//   channel | dir | beat
//   req_    | in  | one track chunk byte plus chunk start flag
//   rsp_    | out | one parsed event (channel message, meta value or error)
//
// One byte per cycle while req_ready is high: each beat is parsed in a
// single pass and its result, if any, lands on the accept edge in the output
// register, or in the skid register while the output register is held.
// Reset (synchronous) returns the parser to the tag check and empties the
// buffer. A two-beat output buffer absorbs a result during an rsp_ready
// stall; req_ready drops only when both slots hold results.
module midi_track_event_parser_core import mtep_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_track_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_kind,
   output logic [27:0] rsp_delta_ticks,
   output logic [7:0]  rsp_status_value,
   output logic [6:0]  rsp_first_data,
   output logic [6:0]  rsp_second_data,
   output logic [23:0] rsp_tempo_value,
   output logic [7:0]  rsp_meter_numerator,
   output logic [7:0]  rsp_meter_denominator_exp
);

   logic    byte_accept;
   logic    res_valid;
   rsp_type res_beat;
   logic    space;
   rsp_type out_beat;

   assign req_ready   = space;
   assign byte_accept = req_valid && space;

   // Parse one byte per accepted beat
   mtep_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .data_byte   (req_data_byte),
      .track_start (req_track_start),
      .res_valid   (res_valid),
      .res_beat    (res_beat)
   );

   // Register results toward the output channel
   mtep_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (byte_accept && res_valid),
      .push_beat (res_beat),
      .space     (space),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_beat  (out_beat)
   );

   assign rsp_event_kind            = out_beat.event_kind;
   assign rsp_delta_ticks           = out_beat.delta_ticks;
   assign rsp_status_value          = out_beat.status_value;
   assign rsp_first_data            = out_beat.first_data;
   assign rsp_second_data           = out_beat.second_data;
   assign rsp_tempo_value           = out_beat.tempo_value;
   assign rsp_meter_numerator       = out_beat.meter_numerator;
   assign rsp_meter_denominator_exp = out_beat.meter_denominator_exp;

endmodule
